// ===== design/pws_pkg.sv =====
// Shared types and constants for the window scorer.
// Holds the configuration record, divider state and result record, and code constants.
// No dependencies.
`default_nettype none

package pws_pkg;

    // Running sum width and its saturation limits
    localparam int                 SUM_W   = 23;
    localparam logic signed [22:0] SUM_MAX = 23'sh3FFFFF;
    localparam logic signed [22:0] SUM_MIN = -23'sh400000;

    // Input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MOTIF_LEN  = 3'd0;
    localparam logic [2:0] REG_DINUC_MODE = 3'd1;
    localparam logic [2:0] REG_COMP_EN    = 3'd2;
    localparam logic [2:0] REG_MIN_SUM    = 3'd3;
    localparam logic [2:0] REG_MAX_SUM    = 3'd4;

    typedef struct packed {
        logic [6:0]  motif_length;
        logic        dinucleotide_mode;
        logic        complement_enable;
        logic [21:0] min_sum;
        logic [21:0] max_sum;
    } cfg_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] score;
        logic [1:0]  status;
    } div_res_t;

endpackage

`default_nettype wire

// ===== design/pws_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on pws_pkg for the register indexes and the cfg_t record.
`default_nettype none

module pws_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output pws_pkg::cfg_t           cfg
);

    pws_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Update the addressed register on the access phase of a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motif_length      <= 7'd1;
            cfg_reg.dinucleotide_mode <= 1'b0;
            cfg_reg.complement_enable <= 1'b0;
            cfg_reg.min_sum           <= 22'd0;
            cfg_reg.max_sum           <= 22'd1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pws_pkg::REG_MOTIF_LEN:  cfg_reg.motif_length      <= pwdata[6:0];
                pws_pkg::REG_DINUC_MODE: cfg_reg.dinucleotide_mode <= pwdata[0];
                pws_pkg::REG_COMP_EN:    cfg_reg.complement_enable <= pwdata[0];
                pws_pkg::REG_MIN_SUM:    cfg_reg.min_sum           <= pwdata[21:0];
                pws_pkg::REG_MAX_SUM:    cfg_reg.max_sum           <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    // Read back, sign-extending the sum bounds
    always_comb
    begin
        case (reg_idx)
            pws_pkg::REG_MOTIF_LEN:  prdata = 32'(cfg_reg.motif_length);
            pws_pkg::REG_DINUC_MODE: prdata = 32'(cfg_reg.dinucleotide_mode);
            pws_pkg::REG_COMP_EN:    prdata = 32'(cfg_reg.complement_enable);
            pws_pkg::REG_MIN_SUM:    prdata = 32'($signed(cfg_reg.min_sum));
            pws_pkg::REG_MAX_SUM:    prdata = 32'($signed(cfg_reg.max_sum));
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/pws_weight_mem.sv =====
// Weight table: one write port and one read port with a registered read.
// No package dependencies.
`default_nettype none

module pws_weight_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WB    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [WB-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [WB-1:0] rdata
);

    logic [WB-1:0] mem [DEPTH];
    logic [WB-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/pws_norm_div.sv =====
// Normalizer: clamps the window sum and divides (sum-min) by (max-min), one
// quotient bit per cycle. Depends on pws_pkg for cfg_t, div_res_t and codes.
`default_nettype none

module pws_norm_div #(
    parameter int SCORE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [22:0] sum,
    input  wire pws_pkg::cfg_t      cfg,
    input  wire logic               take,
    output pws_pkg::div_res_t       res
);

    localparam int CW = $clog2(SCORE_BITS + 1);

    pws_pkg::div_state_t state_reg, state_next;

    logic signed [22:0]    sum_reg;
    logic [21:0]           span_reg;
    logic [22:0]           rem_reg;
    logic [SCORE_BITS-1:0] q_reg;
    logic [CW-1:0]         cnt_reg;
    logic [1:0]            status_reg;

    logic signed [22:0] min23;
    logic signed [22:0] max23;
    logic signed [22:0] span23;
    logic signed [22:0] sum_c;
    logic signed [22:0] diff23;
    logic               degenerate;
    logic               clamped;
    logic               full_scale;
    logic [23:0]        rem2;
    logic [23:0]        span24;
    logic               q_bit;

    // Range setup from the configured bounds
    always_comb
    begin
        min23      = 23'($signed(cfg.min_sum));
        max23      = 23'($signed(cfg.max_sum));
        span23     = max23 - min23;
        degenerate = (max23 <= min23);
        clamped    = (sum_reg < min23) || (sum_reg > max23);
        if (sum_reg < min23)
        begin
            sum_c = min23;
        end
        else if (sum_reg > max23)
        begin
            sum_c = max23;
        end
        else
        begin
            sum_c = sum_reg;
        end
        diff23     = sum_c - min23;
        full_scale = (diff23 == span23);
    end

    // Shift-subtract step
    assign rem2   = {rem_reg, 1'b0};
    assign span24 = 24'(span_reg);
    assign q_bit  = (rem2 >= span24);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pws_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = pws_pkg::DIV_PREP;
                end
            end
            pws_pkg::DIV_PREP:
            begin
                if (degenerate || full_scale)
                begin
                    state_next = pws_pkg::DIV_DONE;
                end
                else
                begin
                    state_next = pws_pkg::DIV_RUN;
                end
            end
            pws_pkg::DIV_RUN:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = pws_pkg::DIV_DONE;
                end
            end
            pws_pkg::DIV_DONE:
            begin
                if (take)
                begin
                    state_next = pws_pkg::DIV_IDLE;
                end
            end
            default: state_next = pws_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pws_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: latch sum, set up the range, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pws_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    sum_reg <= sum;
                end
            end
            pws_pkg::DIV_PREP:
            begin
                span_reg <= span23[21:0];
                rem_reg  <= diff23;
                cnt_reg  <= CW'(SCORE_BITS);
                if (degenerate)
                begin
                    status_reg <= pws_pkg::ST_RANGE;
                    q_reg      <= '0;
                end
                else
                begin
                    status_reg <= clamped ? pws_pkg::ST_CLAMP : pws_pkg::ST_OK;
                    q_reg      <= full_scale ? '1 : '0;
                end
            end
            pws_pkg::DIV_RUN:
            begin
                rem_reg <= q_bit ? 23'(rem2 - span24) : rem2[22:0];
                q_reg   <= {q_reg[SCORE_BITS-2:0], q_bit};
                cnt_reg <= cnt_reg - CW'(1);
            end
            default: ;
        endcase
    end

    // Result outputs
    always_comb
    begin
        res.busy   = (state_reg != pws_pkg::DIV_IDLE);
        res.done   = (state_reg == pws_pkg::DIV_DONE);
        res.score  = 16'(32'(q_reg));
        res.status = status_reg;
    end

endmodule

`default_nettype wire

// ===== design/pwm_window_score_top.sv =====
// Position weight matrix window scorer, top level.
// Depends on pws_pkg, pws_cfg_regs, pws_weight_mem and pws_norm_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: a weight
//   write (operation 0) or one base to score (operation 1, last marks the end of
//   the window). Output channel (out_valid/out_ready) carries score and status,
//   one transaction per window. Registers are written through the APB-style port
//   while the block is idle; the user ensures this, as the block does not enforce it.
//   Weight writes and non-final bases are taken one per cycle while in_ready is
//   high; a base's table lookup is issued at the accept edge and its weight is
//   added into the running sum in the next cycle. A final base holds in_ready low
//   in the lookup stage and while the normalizer is busy: DIV_PREP, then the
//   bit-serial divide in DIV_RUN, one quotient bit per cycle, then DIV_DONE, or
//   straight to DIV_DONE if the range is degenerate or clamped sum equals max_sum.
//   The output register lets new bases enter while a result waits; if a second
//   result finishes while the first is still held, the normalizer holds it and
//   the input stalls until the receiver takes the first.
//   Reset clears the window state and loads the register defaults. The weight
//   table is not cleared: every entry a window reads must be written first.
`default_nettype none

module pwm_window_score_top #(
    parameter int MAX_POSITIONS = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int SCORE_BITS    = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Item channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic [1:0]         base,
    input  wire logic               last,
    input  wire logic [3:0]         weight_row,
    input  wire logic [5:0]         weight_position,
    input  wire logic signed [15:0] weight_value,
    // Result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             score,
    output logic [1:0]              status,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int DEPTH = 16 * MAX_POSITIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADD_W = ((WEIGHT_BITS > pws_pkg::SUM_W) ? WEIGHT_BITS : pws_pkg::SUM_W) + 2;
    localparam logic signed [32:0] WMAX = 33'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [32:0] WMIN = -WMAX - 33'sd1;
    localparam logic [8:0]         MAXP9 = 9'(MAX_POSITIONS);

    pws_pkg::cfg_t     cfg;
    pws_pkg::div_res_t div_res;

    logic in_acc;
    logic acc_score;
    logic acc_write;

    // Window control state, updated at the accept edge
    logic [6:0] pos_cnt_reg, pos_cnt_next;
    logic [1:0] prev_reg, prev_next;

    // Lookup stage
    logic       s1_valid_reg;
    logic       s1_add_reg;
    logic       s1_last_reg;

    logic signed [22:0] sum_reg;
    logic signed [22:0] sum_new;
    logic signed [ADD_W-1:0] sum_wide;
    logic signed [ADD_W-1:0] add_wide;

    logic [1:0]  b_eff;
    logic [8:0]  len9;
    logic [8:0]  pos9;
    logic [8:0]  ridx9;
    logic [3:0]  rrow;
    logic        rd_hit;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic        wpos_ok;
    logic signed [32:0] wv33;
    logic signed [32:0] wsat;
    logic [WEIGHT_BITS-1:0] rdata;

    logic        res_take;
    logic        out_valid_reg;
    logic [15:0] score_reg;
    logic [1:0]  status_reg;

    pws_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stall while a final base is in the lookup stage or the normalizer is busy
    assign in_ready  = !div_res.busy && !(s1_valid_reg && s1_last_reg);
    assign in_acc    = in_valid && in_ready;
    assign acc_score = in_acc && (operation == pws_pkg::OP_SCORE);
    assign acc_write = in_acc && (operation == pws_pkg::OP_WRITE);

    // Select the table entry for this base
    always_comb
    begin
        b_eff = cfg.complement_enable ? ~base : base;
        len9  = (9'(cfg.motif_length) > MAXP9) ? MAXP9 : 9'(cfg.motif_length);
        pos9  = 9'(pos_cnt_reg);
        if (cfg.dinucleotide_mode)
        begin
            rrow   = {prev_reg, b_eff};
            ridx9  = pos9 - 9'd1;
            rd_hit = (pos9 != 9'd0) && (ridx9 < len9);
        end
        else
        begin
            rrow   = {2'b00, b_eff};
            ridx9  = pos9;
            rd_hit = (pos9 < len9);
        end
        raddr = AW'(32'(rrow) * 32'(MAX_POSITIONS) + 32'(ridx9));
    end

    // Weight write address and saturation to the stored width
    always_comb
    begin
        wpos_ok = (9'(weight_position) < MAXP9);
        waddr   = AW'(32'(weight_row) * 32'(MAX_POSITIONS) + 32'(weight_position));
        wv33    = 33'(weight_value);
        if (wv33 > WMAX)
        begin
            wsat = WMAX;
        end
        else if (wv33 < WMIN)
        begin
            wsat = WMIN;
        end
        else
        begin
            wsat = wv33;
        end
    end

    pws_weight_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WB    (WEIGHT_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (acc_write && wpos_ok),
        .waddr (waddr),
        .wdata (wsat[WEIGHT_BITS-1:0]),
        .re    (acc_score && rd_hit),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Advance position and previous base; clear them after the final base
    always_comb
    begin
        pos_cnt_next = pos_cnt_reg;
        prev_next    = prev_reg;
        if (acc_score)
        begin
            if (last)
            begin
                pos_cnt_next = 7'd0;
                prev_next    = 2'd0;
            end
            else
            begin
                pos_cnt_next = (pos_cnt_reg == 7'd127) ? pos_cnt_reg : pos_cnt_reg + 7'd1;
                prev_next    = b_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg  <= 7'd0;
            prev_reg     <= 2'd0;
            s1_valid_reg <= 1'b0;
            s1_add_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            pos_cnt_reg  <= pos_cnt_next;
            prev_reg     <= prev_next;
            s1_valid_reg <= acc_score;
            s1_add_reg   <= acc_score && rd_hit;
            s1_last_reg  <= acc_score && last;
        end
    end

    // Accumulate the looked-up weight with saturation
    always_comb
    begin
        sum_wide = ADD_W'(sum_reg);
        add_wide = s1_add_reg ? ADD_W'($signed(rdata)) : '0;
        sum_wide = sum_wide + add_wide;
        if (sum_wide > ADD_W'(pws_pkg::SUM_MAX))
        begin
            sum_new = pws_pkg::SUM_MAX;
        end
        else if (sum_wide < ADD_W'(pws_pkg::SUM_MIN))
        begin
            sum_new = pws_pkg::SUM_MIN;
        end
        else
        begin
            sum_new = sum_wide[22:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            sum_reg <= s1_last_reg ? '0 : sum_new;
        end
    end

    pws_norm_div #(
        .SCORE_BITS (SCORE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s1_valid_reg && s1_last_reg),
        .sum   (sum_new),
        .cfg   (cfg),
        .take  (res_take),
        .res   (div_res)
    );

    // Output register: load a finished result when the slot is free
    assign res_take = div_res.done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            score_reg  <= div_res.score;
            status_reg <= div_res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign status    = status_reg;

    // A final base blocks the next transaction
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_score && last) |=> !in_ready)
        else $error("input taken right after a final base");

    // Window position restarts after a final base
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_score && last) |=> (pos_cnt_reg == 7'd0 && prev_reg == 2'd0))
        else $error("window state not cleared after final base");

    // A new result comes only from a finished divide
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(div_res.done))
        else $error("result shown without a finished divide");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for pwm_window_score_top: fills the weight table, runs directed
// and random scoring windows, and compares each result with an in-bench predictor.
// Depends on pws_pkg and the design sources; registers are set over the APB-style port.
`timescale 1ns / 100ps

module tb_top;

    localparam int SCORE_W       = 16;
    localparam longint SCORE_TOP = 65535;
    localparam int TABLE_DEPTH   = 1024;
    localparam int MOTIF_CAP     = 64;
    localparam int RANDOM_ITEMS  = 210;
    localparam int SETTLE_CYCLES = SCORE_W + 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int CFG_LO        = -2097152;
    localparam int CFG_HI        = 2097151;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic signed [15:0] W_MAX = 16'sh7FFF;
    localparam logic signed [15:0] W_MIN = 16'sh8000;

    typedef struct {
        logic               op;
        logic [1:0]         nt;
        logic               end_flag;
        logic [3:0]         row;
        logic [5:0]         col;
        logic signed [15:0] wt;
    } item_t;

    typedef struct {
        logic [15:0] score;
        logic [1:0]  status;
    } window_result_t;

    // Block ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = 1'b0;
    logic [1:0]         base = '0;
    logic               last = 1'b0;
    logic [3:0]         weight_row = '0;
    logic [5:0]         weight_position = '0;
    logic signed [15:0] weight_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        score;
    logic [1:0]         status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state and configuration copy
    logic signed [15:0] weight_shadow [TABLE_DEPTH];
    logic signed [22:0] window_sum = '0;
    logic [6:0]         bases_seen = '0;
    logic [1:0]         prior_base = '0;
    logic [6:0]         motif_len_cfg = 7'd1;
    logic               dinuc_cfg = 1'b0;
    logic               comp_cfg = 1'b0;
    logic signed [21:0] min_cfg = 22'sd0;
    logic signed [21:0] max_cfg = 22'sd1;

    item_t          pending_items [$];
    window_result_t expected_scores [$];

    int          send_idle_pct = 12;
    int          recv_idle_pct = 60;
    int          error_count = 0;
    int          items_accepted = 0;
    int          scores_checked = 0;
    int          status_seen [3] = '{0, 0, 0};
    bit          in_taken = 1'b0;
    int unsigned cycle_count = 0;

    pwm_window_score_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .base            (base),
        .last            (last),
        .weight_row      (weight_row),
        .weight_position (weight_position),
        .weight_value    (weight_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .score           (score),
        .status          (status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the window state for one accepted transaction; queue the score on a final base
    task automatic track_item(input item_t it);
        logic [1:0]     nt;
        int             p;
        int             span_len;
        longint         addend;
        longint         acc;
        longint         lo;
        longint         hi;
        longint         s;
        window_result_t res;
        if (it.op == pws_pkg::OP_WRITE)
        begin
            weight_shadow[{it.row, it.col}] = it.wt;
            return;
        end
        nt = comp_cfg ? 2'd3 - it.nt : it.nt;
        span_len = (motif_len_cfg > MOTIF_CAP) ? MOTIF_CAP : int'(motif_len_cfg);
        p = int'(bases_seen);
        addend = 0;
        // pairs count from the second base on, while the first base of the pair lies inside the motif
        if (dinuc_cfg)
        begin
            if (p >= 1 && p - 1 < span_len)
                addend = weight_shadow[{prior_base, nt, 6'(p - 1)}];
        end
        else if (p < span_len)
            addend = weight_shadow[{2'b00, nt, 6'(p)}];
        acc = longint'(window_sum) + addend;
        if (acc > longint'(pws_pkg::SUM_MAX))
            acc = pws_pkg::SUM_MAX;
        if (acc < longint'(pws_pkg::SUM_MIN))
            acc = pws_pkg::SUM_MIN;
        window_sum = 23'(acc);
        prior_base = nt;
        if (bases_seen < 7'd127)
            bases_seen = bases_seen + 7'd1;
        if (!it.end_flag)
            return;

        // Normalize the window sum into the configured range
        lo = min_cfg;
        hi = max_cfg;
        if (hi <= lo)
        begin
            res.score = '0;
            res.status = pws_pkg::ST_RANGE;
        end
        else
        begin
            s = window_sum;
            res.status = pws_pkg::ST_OK;
            if (s < lo || s > hi)
            begin
                res.status = pws_pkg::ST_CLAMP;
                s = (s < lo) ? lo : hi;
            end
            s = ((s - lo) <<< SCORE_W) / (hi - lo);
            if (s > SCORE_TOP)
                s = SCORE_TOP;
            res.score = s[15:0];
        end
        expected_scores.push_back(res);
        window_sum = '0;
        bases_seen = '0;
        prior_base = '0;
    endtask

    function automatic logic signed [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return W_MAX;
            1: return W_MIN;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void push_write(input logic [3:0] row, input logic [5:0] col,
                                       input logic signed [15:0] wt, input logic end_flag);
        item_t it;
        it.op = pws_pkg::OP_WRITE;
        it.nt = 2'($urandom);
        it.end_flag = end_flag;
        it.row = row;
        it.col = col;
        it.wt = wt;
        pending_items.push_back(it);
    endfunction

    function automatic void push_base(input logic [1:0] nt, input logic end_flag);
        item_t it;
        it.op = pws_pkg::OP_SCORE;
        it.nt = nt;
        it.end_flag = end_flag;
        it.row = 4'($urandom);
        it.col = 6'($urandom);
        it.wt = 16'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_noise_write();
        push_write(4'($urandom), 6'($urandom), rand_weight(), 1'($urandom));
    endfunction

    // One APB transfer: setup cycle, then access cycle ending at the next rising edge
    task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_reg(input logic [2:0] idx, input string name,
                               input logic [31:0] data, input int width);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (32'd1 << width) - 32'd1;
        apb_cycle(1'b1, idx, data, got);
        apb_cycle(1'b0, idx, '0, got);
        if ((got & mask) !== (data & mask))
        begin
            $error("%s readback: expected %0h, got %0h", name, data & mask, got & mask);
            error_count++;
        end
    endtask

    // Wait for every transaction and result to drain, then let the divider finish
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input int len, input bit dn, input bit ce,
                               input int lo, input int hi);
        settle();
        program_reg(pws_pkg::REG_MOTIF_LEN, "motif_length", 32'(len), 7);
        program_reg(pws_pkg::REG_DINUC_MODE, "dinucleotide_mode", 32'(dn), 1);
        program_reg(pws_pkg::REG_COMP_EN, "complement_enable", 32'(ce), 1);
        program_reg(pws_pkg::REG_MIN_SUM, "min_sum", 32'(lo), 22);
        program_reg(pws_pkg::REG_MAX_SUM, "max_sum", 32'(hi), 22);
        motif_len_cfg = 7'(len);
        dinuc_cfg = dn;
        comp_cfg = ce;
        min_cfg = 22'(lo);
        max_cfg = 22'(hi);
    endtask

    // Input driver: present the next queued item once the current one is taken
    always @(negedge clk)
    begin
        item_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    operation <= nxt.op;
                    base <= nxt.nt;
                    last <= nxt.end_flag;
                    weight_row <= nxt.row;
                    weight_position <= nxt.col;
                    weight_value <= nxt.wt;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        item_t          seen;
        window_result_t want;
        if (rst_n)
        begin
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                seen.op = operation;
                seen.nt = base;
                seen.end_flag = last;
                seen.row = weight_row;
                seen.col = weight_position;
                seen.wt = weight_value;
                track_item(seen);
                items_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("unexpected result: score %0d status %0d", score, status);
                    error_count++;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    scores_checked++;
                    status_seen[want.status]++;
                    if (score !== want.score)
                    begin
                        $error("score mismatch: expected %0d, got %0d", want.score, score);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hold a hard cap on run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_scores.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        int total_random;
        int stop_at;
        int wlen;
        int span;
        int lim;
        int lo;
        int hi;
        int len;
        int pick;
        int swap;
        bit dn;
        bit ce;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill every table entry so no window ever reads an unwritten weight
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < MOTIF_CAP; c++)
                push_write(4'(r), 6'(c), rand_weight(), 1'($urandom));

        // Directed: reset settings, write carrying last, extreme weights, bases past motif
        push_write(4'd0, 6'd0, W_MAX, 1'b1);
        push_base(BASE_A, 1'b1);
        push_write(4'd1, 6'd0, W_MIN, 1'b0);
        push_base(BASE_C, 1'b0);
        push_base(BASE_G, 1'b1);

        // Sum exactly at max saturates the score
        load_config(1, 1'b0, 1'b0, 0, 32767);
        push_base(BASE_A, 1'b1);

        // Plain window plus one base beyond the motif
        load_config(3, 1'b0, 1'b0, -100000, 100000);
        push_base(BASE_T, 1'b0);
        push_base(BASE_G, 1'b0);
        push_base(BASE_C, 1'b0);
        push_base(BASE_A, 1'b1);

        // Pairs with complemented bases
        load_config(2, 1'b1, 1'b1, -70000, 70000);
        push_base(BASE_A, 1'b0);
        push_base(BASE_C, 1'b0);
        push_base(BASE_G, 1'b1);

        // Zero-length motif scores nothing
        load_config(0, 1'b0, 1'b0, -5, 5);
        push_base(BASE_T, 1'b0);
        push_base(BASE_G, 1'b1);

        // Degenerate range: max equal to min
        load_config(4, 1'b0, 1'b0, 100, 100);
        push_base(BASE_C, 1'b1);

        // Random phases: extremes first, then random settings
        total_random = 0;
        for (int ph = 0; total_random < RANDOM_ITEMS; ph++)
        begin
            dn = 1'($urandom);
            ce = 1'($urandom);
            case (ph)
                0:
                begin
                    len = 64; dn = 1'b0; ce = 1'b0; lo = CFG_LO; hi = CFG_HI;
                end
                1:
                begin
                    len = 127; dn = 1'b1; ce = 1'b1; lo = CFG_LO; hi = CFG_HI;
                end
                2:
                begin
                    len = 1; dn = 1'b1; ce = 1'b0; lo = -40000; hi = 40000;
                end
                3:
                begin
                    len = 8; dn = 1'b0; ce = 1'b1; lo = CFG_HI; hi = CFG_LO;
                end
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        len = 0;
                    else if (pick == 1)
                        len = 64;
                    else if (pick == 2)
                        len = $urandom_range(65, 127);
                    else
                        len = $urandom_range(1, 8);
                    span = (len == 0) ? 1 : ((len > MOTIF_CAP) ? MOTIF_CAP : len);
                    lim = span * 32768;
                    if (lim > CFG_HI)
                        lim = CFG_HI;
                    lo = -int'($urandom_range(0, lim));
                    hi = int'($urandom_range(0, lim));
                    case ($urandom_range(0, 11))
                        0: hi = lo;
                        1:
                        begin
                            lo = CFG_LO;
                            hi = CFG_HI;
                        end
                        2:
                        begin
                            swap = lo;
                            lo = hi;
                            hi = swap;
                        end
                        3:
                        begin
                            lo = int'($urandom_range(0, lim / 2));
                            hi = lo + int'($urandom_range(1, lim / 2));
                        end
                        default: ;
                    endcase
                end
            endcase
            load_config(len, dn, ce, lo, hi);

            // Sender light and receiver heavy, then swapped, then no idling
            if (total_random < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 60;
            end
            else if (total_random < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Mostly complete windows, with stray weight writes mixed in
            stop_at = total_random + int'($urandom_range(20, 40));
            span = (len > MOTIF_CAP) ? MOTIF_CAP : len;
            while (total_random < stop_at)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_noise_write();
                    total_random++;
                end
                else
                begin
                    if ($urandom_range(0, 29) == 0)
                        wlen = $urandom_range(120, 140);
                    else
                        wlen = $urandom_range(1, span + 3);
                    for (int i = 0; i < wlen; i++)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            push_noise_write();
                            total_random++;
                        end
                        push_base(2'($urandom), i == wlen - 1);
                    end
                    total_random += wlen;
                end
            end
        end

        settle();
        $display("Run covered %0d accepted transactions and %0d checked window scores",
                 items_accepted, scores_checked);
        $display("Result mix: %0d in range, %0d clamped, %0d with degenerate range",
                 status_seen[pws_pkg::ST_OK], status_seen[pws_pkg::ST_CLAMP],
                 status_seen[pws_pkg::ST_RANGE]);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
